// ----- rtl/lct_pkg.sv -----
`default_nettype none
package lct_pkg;
    localparam int CACHE_ENTRIES = 8192;
    localparam int HASH_BUCKETS  = 4096;
    localparam int KEY_BITS      = 32;
    localparam int BLOCK_W       = 32;
    localparam int SLOT_W        = 13;
    localparam int COUNT_W       = 32;
endpackage
`default_nettype wire

// ----- rtl/lru_cache_tag_lookup.sv -----
`default_nettype none
// Channel   | direction | handshake               | words
// command   | in        | i_start & !o_busy       | i_block_number
// result    | out       | o_valid, one cycle      | o_hit o_slot o_evicted_* o_*_total
//
// Steps after the accepting edge: S_HEAD gets the bucket head, S_WALK compares
// the chain entries, one per cycle, and S_DEC decides. A fill then runs S_CP1,
// S_CP2, S_RP and S_OUT; a hit on the most recent entry S_CU1, S_CU2, S_CP1,
// S_CP2 and S_OUT; any other hit S_RU1, S_RU2, S_CU1 to S_CP2, S_RP and S_OUT;
// an eviction first reads the victim in S_VIC, then goes on like any other hit.
// Each memory has one read and one write port, so link updates get separate states.
// After reset, a clearing pass empties the bucket heads, one bucket a cycle,
// with o_busy high. The result cannot be stalled. o_busy stays high through
// the result cycle, and the next word is taken once the block is back in S_IDLE.
module lru_cache_tag_lookup #(
    parameter int CACHE_ENTRIES = lct_pkg::CACHE_ENTRIES,
    parameter int HASH_BUCKETS  = lct_pkg::HASH_BUCKETS,
    parameter int KEY_BITS      = lct_pkg::KEY_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [lct_pkg::BLOCK_W-1:0] i_block_number,
    output logic                             o_busy,
    output logic                             o_valid,
    output logic                             o_hit,
    output logic [lct_pkg::SLOT_W-1:0]       o_slot,
    output logic                             o_evicted_valid,
    output logic [lct_pkg::BLOCK_W-1:0]      o_evicted_block,
    output logic [lct_pkg::COUNT_W-1:0]      o_hit_total,
    output logic [lct_pkg::COUNT_W-1:0]      o_access_total
);
    localparam int SW = $clog2(CACHE_ENTRIES);      // slot index width
    localparam int LW = $clog2(CACHE_ENTRIES + 1);  // link width, holds "none"
    localparam int BW = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
    localparam logic [LW-1:0] NONE = LW'(CACHE_ENTRIES);
    localparam logic [BW-1:0] BLAST = BW'(HASH_BUCKETS - 1);
    localparam int CW = lct_pkg::COUNT_W;
    localparam int OSW = lct_pkg::SLOT_W;
    localparam int OBW = lct_pkg::BLOCK_W;

    // states: each one touches the memories at most once per port
    typedef enum logic [13:0] {
        S_CLR  = 14'b00000000000001,
        S_IDLE = 14'b00000000000010,
        S_HEAD = 14'b00000000000100, // bucket head read returns
        S_WALK = 14'b00000000001000, // entry read returns, compare
        S_DEC  = 14'b00000000010000, // choose hit/fill/evict
        S_RU1  = 14'b00000000100000, // recency unlink: newer side
        S_RU2  = 14'b00000001000000, // recency unlink: older side
        S_CU1  = 14'b00000010000000, // chain unlink: prev side / head
        S_CU2  = 14'b00000100000000, // chain unlink: next side
        S_CP1  = 14'b00001000000000, // chain push: read new head
        S_CP2  = 14'b00010000000000, // chain push: write links
        S_RP   = 14'b00100000000000, // recency push
        S_OUT  = 14'b01000000000000,
        S_VIC  = 14'b10000000000000  // victim read returns
    } t_state;

    // memories
    logic [KEY_BITS-1:0] m_key   [CACHE_ENTRIES];
    logic [LW-1:0]       m_newer [CACHE_ENTRIES];
    logic [LW-1:0]       m_older [CACHE_ENTRIES];
    logic [LW-1:0]       m_cnext [CACHE_ENTRIES];
    logic [LW-1:0]       m_cprev [CACHE_ENTRIES];
    logic [LW-1:0]       m_head  [HASH_BUCKETS];

    t_state r_state;
    logic [KEY_BITS-1:0] r_key;
    logic [BW-1:0]       r_bkt;
    logic [LW-1:0]       r_p;
    logic [SW-1:0]       r_slot;
    logic [LW-1:0]       r_steps_left;
    logic                r_hit, r_ev, r_fill;
    logic [KEY_BITS-1:0] r_evkey;
    logic [LW-1:0]       r_n, r_o; // recency links of slot
    logic [LW-1:0]       r_cn, r_cp; // chain links of slot
    logic [LW-1:0]       r_mr, r_lr;
    logic [LW-1:0]       r_fill_cnt;
    logic [CW-1:0]       r_hits, r_accs;
    logic [BW-1:0]       r_clr;

    // registered read data
    logic [KEY_BITS-1:0] q_key;
    logic [LW-1:0] q_newer, q_older, q_cnext, q_cprev, q_head;

    // read address: one per memory group
    logic [SW-1:0] rd_slot;
    logic [BW-1:0] rd_bkt;
    logic [BW-1:0] key_bkt, in_bkt;
    logic [KEY_BITS-1:0] in_key;
    logic [SW-1:0] victim;

    always_comb begin
        in_key  = KEY_BITS'(i_block_number);
        in_bkt  = BW'(in_key % HASH_BUCKETS);
        key_bkt = BW'(q_key % HASH_BUCKETS);
        victim  = (r_lr == NONE) ? '0 : r_lr[SW-1:0];
    end

    always_comb begin
        rd_bkt  = (r_state == S_IDLE) ? in_bkt : r_bkt;
        case (r_state)
            S_HEAD: rd_slot = q_head[SW-1:0];
            S_WALK: rd_slot = q_cnext[SW-1:0];
            S_DEC: rd_slot = victim;
            default: rd_slot = r_p[SW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        q_key   <= m_key[rd_slot];
        q_newer <= m_newer[rd_slot];
        q_older <= m_older[rd_slot];
        q_cnext <= m_cnext[rd_slot];
        q_cprev <= m_cprev[rd_slot];
        q_head  <= m_head[rd_bkt];
    end

    logic match;
    always_comb match = (q_key == r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_mr       <= '0;
            r_lr       <= '0;
            r_fill_cnt <= '0;
            r_hits     <= '0;
            r_accs     <= '0;
        end else begin
            case (r_state)
                S_CLR: begin
                    m_head[r_clr] <= NONE;
                    r_clr <= r_clr + BW'(1);
                    if (r_clr == BLAST) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_key   <= in_key;
                        r_bkt   <= in_bkt;
                        r_hit   <= 1'b0;
                        r_ev    <= 1'b0;
                        r_fill  <= 1'b0;
                        r_state <= S_HEAD;
                        r_steps_left <= NONE;
                        if (r_accs != '1) r_accs <= r_accs + CW'(1);
                    end
                end
                S_HEAD: begin
                    r_p <= q_head;
                    r_state <= (q_head == NONE) ? S_DEC : S_WALK;
                end
                S_WALK: begin
                    // q_* hold entry r_p
                    if (match) begin
                        r_hit  <= 1'b1;
                        r_slot <= r_p[SW-1:0];
                        r_n <= q_newer; r_o <= q_older;
                        r_cn <= q_cnext; r_cp <= q_cprev;
                        r_state <= S_DEC;
                    end else begin
                        r_p <= q_cnext;
                        r_steps_left <= r_steps_left - LW'(1);
                        if (q_cnext == NONE || r_steps_left == LW'(1)) r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (r_hit) begin
                        if (r_hits != '1) r_hits <= r_hits + CW'(1);
                        r_state <= (LW'(r_slot) == r_mr) ? S_CU1 : S_RU1;
                    end else if (r_fill_cnt != NONE) begin
                        r_fill <= 1'b1;
                        r_slot <= r_fill_cnt[SW-1:0];
                        m_key[r_fill_cnt[SW-1:0]] <= r_key;
                        r_fill_cnt <= r_fill_cnt + LW'(1);
                        r_state <= S_CP1;
                    end else begin
                        // cache full: replace the least recent entry
                        r_ev <= 1'b1;
                        r_slot <= victim;
                        r_state <= S_VIC;
                    end
                end
                S_VIC: begin
                    r_n <= q_newer; r_o <= q_older;
                    r_cn <= q_cnext; r_cp <= q_cprev;
                    r_evkey <= q_key;
                    r_bkt <= key_bkt;
                    r_state <= S_RU1;
                end
                S_RU1: begin
                    if (r_n != NONE) m_older[r_n[SW-1:0]] <= r_o;
                    else r_mr <= r_o;
                    r_state <= S_RU2;
                end
                S_RU2: begin
                    if (r_o != NONE) m_newer[r_o[SW-1:0]] <= r_n;
                    else r_lr <= r_n;
                    r_state <= S_CU1;
                end
                S_CU1: begin
                    if (r_cp != NONE) m_cnext[r_cp[SW-1:0]] <= r_cn;
                    else m_head[r_bkt] <= r_cn;
                    r_state <= S_CU2;
                end
                S_CU2: begin
                    if (r_cn != NONE) m_cprev[r_cn[SW-1:0]] <= r_cp;
                    if (r_ev) m_key[r_slot] <= r_key;
                    r_bkt <= BW'(r_key % HASH_BUCKETS);
                    r_state <= S_CP1;
                end
                S_CP1: begin
                    // head of the new bucket is read this cycle
                    m_cprev[r_slot] <= NONE;
                    r_state <= S_CP2;
                end
                S_CP2: begin
                    m_cnext[r_slot] <= q_head;
                    if (q_head != NONE) m_cprev[q_head[SW-1:0]] <= LW'(r_slot);
                    m_head[r_bkt] <= LW'(r_slot);
                    // hit on the most recent entry keeps the recency order
                    if (r_hit && LW'(r_slot) == r_mr) begin
                        r_state <= S_OUT;
                    end else begin
                        m_newer[r_slot] <= NONE;
                        r_state <= S_RP;
                    end
                end
                S_RP: begin
                    if ((r_fill && r_fill_cnt == LW'(1)) || r_mr == NONE) begin
                        m_older[r_slot] <= NONE;
                        r_lr <= LW'(r_slot);
                    end else begin
                        m_older[r_slot] <= r_mr;
                        m_newer[r_mr[SW-1:0]] <= LW'(r_slot);
                    end
                    r_mr <= LW'(r_slot);
                    r_state <= S_OUT;
                end
                S_OUT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_busy          = (r_state != S_IDLE);
        o_valid         = (r_state == S_OUT);
        o_hit           = r_hit;
        o_slot          = OSW'(r_slot);
        o_evicted_valid = r_ev;
        o_evicted_block = r_ev ? OBW'(r_evkey) : '0;
        o_hit_total     = r_hits;
        o_access_total  = r_accs;
    end
endmodule
`default_nettype wire

// ----- rtl/lru_cache_tag_lookup_chk.sv -----
`default_nettype none
module lru_cache_tag_lookup_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_start,
    input wire logic        o_busy,
    input wire logic        o_valid,
    input wire logic        o_hit,
    input wire logic        o_evicted_valid,
    input wire logic [31:0] o_evicted_block,
    input wire logic [31:0] o_access_total
);
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy) else $error("result without busy");
    a_hit_noev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_evicted_valid)) else $error("hit and evict");
    a_evzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_evicted_valid) |-> o_evicted_block == 32'd0)
        else $error("evicted block not zero");
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("two results in a row");
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_access_total >= $past(o_access_total)))
        else $error("access count fell");
endmodule

bind lru_cache_tag_lookup lru_cache_tag_lookup_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_valid(o_valid), .o_hit(o_hit), .o_evicted_valid(o_evicted_valid),
    .o_evicted_block(o_evicted_block), .o_access_total(o_access_total)
);
`default_nettype wire
